// File: rtl/counting_sort_engine_unit_defines.svh
// assertion macros for the counting sort engine
`ifndef COUNTING_SORT_ENGINE_UNIT_DEFINES_SVH
`define COUNTING_SORT_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("counting sort engine check failed");
`define CSE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("counting sort engine check failed");
`else
`define CSE_ASSERT(lbl, clk, rst_n, prop)
`define CSE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/cse_pkg.sv
package cse_pkg;

  localparam int unsigned KEY_W   = 10;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TDATA_W = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_OK   = 2'd0,
    KIND_LOAD_FULL = 2'd1,
    KIND_KEY       = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic  clr_step;
    logic  ld_rd;
    logic  ld_wr;
    logic  scan_init;
    logic  scan_step;
    logic  take_hit;
    logic  resp_en;
    kind_e resp_kind;
  } cse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_fetch;
    logic full;
    logic empty;
    logic clr_done;
    logic hit;
    logic miss_end;
    logic out_free;
  } cse_status_t;

endpackage

// File: rtl/cse_ram.sv
module cse_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cse_dp.sv
module cse_dp #(
  parameter int unsigned KEY_BITS  = 10,
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cse_pkg::cse_cmd_t           cmd_i,
  output cse_pkg::cse_status_t        status_o,
  input  logic                        in_op_i,
  input  logic [cse_pkg::KEY_W-1:0]   in_key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cse_pkg::KIND_W-1:0]  out_kind_o,
  output logic [cse_pkg::KEY_W-1:0]   out_key_o,
  output logic                        out_last_o
);

  localparam int unsigned NumBins = 1 << KEY_BITS;
  localparam int unsigned CntW    = $clog2(MAX_ITEMS + 1);
  localparam logic [KEY_BITS-1:0] MaxAddr = {KEY_BITS{1'b1}};

  logic [KEY_BITS-1:0] key_m;
  logic [KEY_BITS-1:0] key_q;
  logic [CntW-1:0]     held_q, held_d;
  logic [KEY_BITS-1:0] scan_q, scan_d;
  logic [KEY_BITS-1:0] clr_ptr_q;
  logic [KEY_BITS-1:0] ptr_q;
  logic                issue_q;
  logic                chk_vld_q;
  logic [KEY_BITS-1:0] chk_addr_q;
  logic [cse_pkg::KEY_W-1:0] res_key_q;
  logic                res_last_q;

  logic                out_valid_q;
  logic [cse_pkg::KIND_W-1:0] out_kind_q;
  logic [cse_pkg::KEY_W-1:0]  out_key_q;
  logic                out_last_q;
  logic [cse_pkg::KEY_W-1:0]  out_key_d;
  logic                out_last_d;

  logic                ram_we, ram_re;
  logic [KEY_BITS-1:0] ram_waddr, ram_raddr;
  logic [CntW-1:0]     ram_wdata, ram_rdata;
  logic                held_one;

  assign key_m    = KEY_BITS'(in_key_i);
  assign held_one = (held_q == CntW'(1));

  // bin store: one read and one write per cycle
  assign ram_re    = cmd_i.ld_rd | cmd_i.scan_init | (cmd_i.scan_step & issue_q);
  assign ram_raddr = cmd_i.ld_rd ? key_m : (cmd_i.scan_init ? scan_q : ptr_q);
  assign ram_we    = cmd_i.clr_step | cmd_i.ld_wr | cmd_i.take_hit;

  always_comb begin
    if (cmd_i.clr_step) begin
      ram_waddr = clr_ptr_q;
      ram_wdata = '0;
    end else if (cmd_i.ld_wr) begin
      ram_waddr = key_q;
      ram_wdata = ram_rdata + CntW'(1);
    end else begin
      ram_waddr = chk_addr_q;
      ram_wdata = ram_rdata - CntW'(1);
    end
  end

  cse_ram #(
    .WIDTH (CntW),
    .DEPTH (NumBins)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    held_d = held_q;
    scan_d = scan_q;
    if (cmd_i.ld_wr) begin
      held_d = held_q + CntW'(1);
      if (key_q < scan_q) begin
        scan_d = key_q;
      end
    end else if (cmd_i.take_hit) begin
      held_d = held_q - CntW'(1);
      // drain complete: scan restarts from bin zero
      scan_d = held_one ? '0 : chk_addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      scan_q    <= '0;
      clr_ptr_q <= '0;
      issue_q   <= 1'b0;
      chk_vld_q <= 1'b0;
    end else begin
      held_q <= held_d;
      scan_q <= scan_d;
      if (cmd_i.clr_step) begin
        clr_ptr_q <= clr_ptr_q + KEY_BITS'(1);
      end
      if (cmd_i.scan_init) begin
        chk_vld_q <= 1'b1;
        issue_q   <= (scan_q != MaxAddr);
      end else if (cmd_i.scan_step) begin
        chk_vld_q <= issue_q;
        if (issue_q) begin
          issue_q <= (ptr_q != MaxAddr);
        end
      end else if (cmd_i.take_hit) begin
        chk_vld_q <= 1'b0;
        issue_q   <= 1'b0;
      end
    end
  end

  // scan pointers: read address runs one bin ahead of the checked one
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_rd) begin
      key_q <= key_m;
    end
    if (cmd_i.scan_init) begin
      chk_addr_q <= scan_q;
      ptr_q      <= scan_q + KEY_BITS'(1);
    end else if (cmd_i.scan_step && issue_q) begin
      chk_addr_q <= ptr_q;
      ptr_q      <= ptr_q + KEY_BITS'(1);
    end
    if (cmd_i.take_hit) begin
      res_key_q  <= cse_pkg::KEY_W'(chk_addr_q);
      res_last_q <= held_one;
    end
  end

  always_comb begin
    out_key_d  = '0;
    out_last_d = 1'b0;
    if (cmd_i.resp_kind == cse_pkg::KIND_KEY) begin
      out_key_d  = cmd_i.take_hit ? cse_pkg::KEY_W'(chk_addr_q) : res_key_q;
      out_last_d = cmd_i.take_hit ? held_one : res_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_en) begin
      out_kind_q <= cmd_i.resp_kind;
      out_key_q  <= out_key_d;
      out_last_q <= out_last_d;
    end
  end

  assign status_o.in_fetch = (in_op_i == cse_pkg::OP_FETCH);
  assign status_o.full     = (held_q >= CntW'(MAX_ITEMS));
  assign status_o.empty    = (held_q == '0);
  assign status_o.clr_done = (clr_ptr_q == MaxAddr);
  assign status_o.hit      = chk_vld_q && (ram_rdata != '0);
  assign status_o.miss_end = chk_vld_q && (ram_rdata == '0) && (chk_addr_q == MaxAddr);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_key_o   = out_key_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/cse_ctrl.sv
module cse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cse_pkg::cse_status_t status_i,
  output cse_pkg::cse_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LD_WR = 6'b000100,
    S_SCAN  = 6'b001000,
    S_RESP  = 6'b010000,
    S_SPARE = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  cse_pkg::kind_e kind_q, kind_d;
  logic           accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.resp_kind = kind_q;
    state_d         = state_q;
    kind_d          = kind_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!status_i.in_fetch && status_i.full) begin
            cmd_o.resp_kind = cse_pkg::KIND_LOAD_FULL;
            kind_d          = cse_pkg::KIND_LOAD_FULL;
          end else if (status_i.in_fetch && status_i.empty) begin
            cmd_o.resp_kind = cse_pkg::KIND_EMPTY;
            kind_d          = cse_pkg::KIND_EMPTY;
          end
          if (!status_i.in_fetch && !status_i.full) begin
            cmd_o.ld_rd = 1'b1;
            state_d     = S_LD_WR;
          end else if (status_i.in_fetch && !status_i.empty) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end else if (status_i.out_free) begin
            cmd_o.resp_en = 1'b1;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_LD_WR: begin
        cmd_o.ld_wr     = 1'b1;
        cmd_o.resp_kind = cse_pkg::KIND_LOAD_OK;
        kind_d          = cse_pkg::KIND_LOAD_OK;
        cmd_o.resp_en   = status_i.out_free;
        state_d         = status_i.out_free ? S_IDLE : S_RESP;
      end
      S_SCAN: begin
        if (status_i.hit) begin
          cmd_o.take_hit  = 1'b1;
          cmd_o.resp_kind = cse_pkg::KIND_KEY;
          kind_d          = cse_pkg::KIND_KEY;
          cmd_o.resp_en   = status_i.out_free;
          state_d         = status_i.out_free ? S_IDLE : S_RESP;
        end else if (status_i.miss_end) begin
          cmd_o.resp_kind = cse_pkg::KIND_EMPTY;
          kind_d          = cse_pkg::KIND_EMPTY;
          cmd_o.resp_en   = status_i.out_free;
          state_d         = status_i.out_free ? S_IDLE : S_RESP;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_RESP: begin
        cmd_o.resp_en = status_i.out_free;
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kind_q  <= cse_pkg::KIND_LOAD_OK;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// File: rtl/counting_sort_engine_unit.sv
// counting sort engine: loads read and then write their bin, and fetches scan the bins past empty ones,
// with the bin store's single read port setting the scan speed.
// dropped loads and fetches on an empty store answer from idle without touching the bins.
// reset: control clears at once, then a clearing pass over all 2^KEY_BITS bins zeroes them,
// with s_axis_tready_o low until it ends.
`include "counting_sort_engine_unit_defines.svh"

module counting_sort_engine_unit #(
  parameter int unsigned KEY_BITS  = 10,
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [cse_pkg::TDATA_W-1:0]   s_axis_tdata_i,  // [9:0] key_in
  input  logic                          s_axis_tuser_i,  // [0] op
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [cse_pkg::TDATA_W-1:0]   m_axis_tdata_o,  // [9:0] key_out
  output logic [cse_pkg::KIND_W-1:0]    m_axis_tuser_o,  // [1:0] kind
  output logic                          m_axis_tlast_o
);

  cse_pkg::cse_cmd_t         cmd;
  cse_pkg::cse_status_t      status;
  logic [cse_pkg::KEY_W-1:0] key_out;

  cse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cse_dp #(
    .KEY_BITS  (KEY_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (s_axis_tuser_i),
    .in_key_i    (s_axis_tdata_i[cse_pkg::KEY_W-1:0]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_key_o   (key_out),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = cse_pkg::TDATA_W'(key_out);

  // a load that fits updates its bin on the next cycle
  `CSE_ASSERT(a_load_writes, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i && !status.full) |=> cmd.ld_wr)
  // no beat taken during the clearing pass
  `CSE_ASSERT_ALWAYS(a_clear_blocks_input, clk_i, cmd.clr_step |-> !s_axis_tready_o)
  // the result register is only loaded when it has room
  `CSE_ASSERT(a_resp_has_room, clk_i, rst_ni, cmd.resp_en |-> (!m_axis_tvalid_o || m_axis_tready_i))
  // a bin is only decremented when the scan saw it nonzero
  `CSE_ASSERT(a_hit_is_nonzero, clk_i, rst_ni, cmd.take_hit |-> (status.hit && !status.empty))

endmodule
